[sv/rdcu_pkg.sv]
package rdcu_pkg;

    // Default word format of the cell values.
    localparam int DEF_WORD_BITS = 24;
    localparam int DEF_FRAC_BITS = 16;

    // Intermediate results saturate to 32 bits; products are full width.
    localparam int ACC_BITS  = 32;
    localparam int PROD_BITS = 2 * ACC_BITS;
    localparam int EXT_BITS  = PROD_BITS + 2;

    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    // Register map, one word per register.
    typedef enum logic [2:0] {
        REG_TIME_STEP,
        REG_GAIN_X,
        REG_GAIN_Y,
        REG_INV_A,
        REG_B_OFFSET,
        REG_INV_EPS,
        REG_STIMULUS
    } t_reg_idx;

    localparam logic        [22:0] TIME_STEP_RST = 23'd1311;
    localparam logic        [22:0] GAIN_X_RST    = 23'd409600;
    localparam logic        [22:0] GAIN_Y_RST    = 23'd409600;
    localparam logic        [22:0] INV_A_RST     = 23'd78019;
    localparam logic signed [23:0] B_OFFSET_RST  = 24'sd4588;
    localparam logic        [22:0] INV_EPS_RST   = 23'd2184533;
    localparam logic signed [23:0] STIMULUS_RST  = 24'sd98304;

    // Working set of one cell as it moves down the pipeline. Each stage
    // rewrites the fields it owns and passes the rest along.
    typedef struct packed {
        logic signed [ACC_BITS-1:0]  u;
        logic signed [ACC_BITS-1:0]  v;
        logic signed [ACC_BITS-1:0]  xs;
        logic signed [ACC_BITS-1:0]  ys;
        logic signed [ACC_BITS-1:0]  tu;
        logic signed [ACC_BITS-1:0]  mu;
        logic signed [ACC_BITS-1:0]  sv;
        logic signed [ACC_BITS-1:0]  du;
        logic signed [ACC_BITS-1:0]  dv;
        logic signed [PROD_BITS-1:0] px;
        logic signed [PROD_BITS-1:0] py;
        logic signed [PROD_BITS-1:0] pu;
        logic signed [PROD_BITS-1:0] pm;
        logic signed [PROD_BITS-1:0] pv;
        logic                        stim;
        logic                        lo;
        logic                        hi;
        logic                        cu;
        logic                        cm;
    } t_cell;

endpackage

[sv/reaction_diffusion_cell_update.sv]
// One forward-Euler step of one cell of a two-variable excitable medium in
// signed fixed point (FRAC_BITS fraction bits in WORD_BITS-bit words). A
// request carries the cell's u and v, its four u neighbors and a stimulus
// flag; the result carries the new u and v, saturated to the word range, and
// a flag that is set when an intermediate or final value it uses was clipped. The
// block accepts one cell every clock while the output is not stalled. The
// pipeline depth is set by the reaction term, a chain of three dependent
// multiply-and-round steps followed by the time-step multiply, each
// multiplier and each rounding in a stage of its own. Stalls on the output
// hold the pipeline without loss, and empty stages still fill while a result
// waits. The user must write coefficients over the APB port only while no
// cell is in flight, unenforced by the block; all start live at their defaults.
module reaction_diffusion_cell_update #(
    parameter int WORD_BITS = rdcu_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = rdcu_pkg::DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Fields from bit 0: u_center, v_center, u_north, u_south, u_west, u_east.
    input  logic [((6*WORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
    // Fields from bit 0: stimulate.
    input  logic [0:0]                         s_axis_tuser,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: u_next, v_next.
    output logic [((2*WORD_BITS+7)/8)*8-1:0]   m_axis_tdata,
    // Fields from bit 0: saturated.
    output logic [0:0]                         m_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rdcu_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [rdcu_pkg::DATA_BITS-1:0]     pwdata,
    output logic [rdcu_pkg::DATA_BITS-1:0]     prdata,
    output logic                               pready
);

    localparam int NST      = 16;
    localparam int ACC      = rdcu_pkg::ACC_BITS;
    localparam int PROD     = rdcu_pkg::PROD_BITS;
    localparam int EXT      = rdcu_pkg::EXT_BITS;
    localparam int OUT_BITS = ((2*WORD_BITS+7)/8)*8;

    localparam logic signed [ACC-1:0] ONE   = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [ACC-1:0] K675  = 32'sd27 <<< (FRAC_BITS - 2);
    localparam logic signed [EXT-1:0] HALF  = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [EXT-1:0] MAX32 = 66'sd2147483647;
    localparam logic signed [EXT-1:0] MIN32 = -66'sd2147483648;
    localparam logic signed [ACC-1:0] MAXW  = 32'sh7fffffff >>> (32 - WORD_BITS);
    localparam logic signed [ACC-1:0] MINW  = ~MAXW;

    function automatic logic signed [ACC-1:0] sat32(input logic signed [EXT-1:0] x);
        if (x > MAX32) begin
            return MAX32[ACC-1:0];
        end else if (x < MIN32) begin
            return MIN32[ACC-1:0];
        end
        return x[ACC-1:0];
    endfunction

    function automatic logic ovf32(input logic signed [EXT-1:0] x);
        return (x > MAX32) || (x < MIN32);
    endfunction

    function automatic logic signed [PROD-1:0] mul(input logic signed [ACC-1:0] a,
                                                    input logic signed [ACC-1:0] b);
        return PROD'(a) * PROD'(b);
    endfunction

    // Round half toward plus infinity, then drop the fraction bits.
    function automatic logic signed [EXT-1:0] rnd(input logic signed [PROD-1:0] p);
        logic signed [EXT-1:0] q;
        q = EXT'(p) + HALF;
        return q >>> FRAC_BITS;
    endfunction

    function automatic logic signed [ACC-1:0] satw(input logic signed [ACC-1:0] x);
        if (x > MAXW) begin
            return MAXW;
        end else if (x < MINW) begin
            return MINW;
        end
        return x;
    endfunction

    function automatic logic ovfw(input logic signed [ACC-1:0] x);
        return (x > MAXW) || (x < MINW);
    endfunction

    // Configuration registers.
    logic        [22:0] r_time_step;
    logic        [22:0] r_gain_x;
    logic        [22:0] r_gain_y;
    logic        [22:0] r_inv_a;
    logic signed [23:0] r_b_offset;
    logic        [22:0] r_inv_eps;
    logic signed [23:0] r_stimulus;

    logic signed [ACC-1:0] c_h, c_gx, c_gy, c_ia, c_b, c_ie, c_stim;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= rdcu_pkg::TIME_STEP_RST;
            r_gain_x    <= rdcu_pkg::GAIN_X_RST;
            r_gain_y    <= rdcu_pkg::GAIN_Y_RST;
            r_inv_a     <= rdcu_pkg::INV_A_RST;
            r_b_offset  <= rdcu_pkg::B_OFFSET_RST;
            r_inv_eps   <= rdcu_pkg::INV_EPS_RST;
            r_stimulus  <= rdcu_pkg::STIMULUS_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (rdcu_pkg::t_reg_idx'(paddr[4:2]))
                rdcu_pkg::REG_TIME_STEP: r_time_step <= pwdata[22:0];
                rdcu_pkg::REG_GAIN_X:    r_gain_x    <= pwdata[22:0];
                rdcu_pkg::REG_GAIN_Y:    r_gain_y    <= pwdata[22:0];
                rdcu_pkg::REG_INV_A:     r_inv_a     <= pwdata[22:0];
                rdcu_pkg::REG_B_OFFSET:  r_b_offset  <= $signed(pwdata[23:0]);
                rdcu_pkg::REG_INV_EPS:   r_inv_eps   <= pwdata[22:0];
                rdcu_pkg::REG_STIMULUS:  r_stimulus  <= $signed(pwdata[23:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (rdcu_pkg::t_reg_idx'(paddr[4:2]))
            rdcu_pkg::REG_TIME_STEP: prdata = {9'd0, r_time_step};
            rdcu_pkg::REG_GAIN_X:    prdata = {9'd0, r_gain_x};
            rdcu_pkg::REG_GAIN_Y:    prdata = {9'd0, r_gain_y};
            rdcu_pkg::REG_INV_A:     prdata = {9'd0, r_inv_a};
            rdcu_pkg::REG_B_OFFSET:  prdata = {8'd0, r_b_offset};
            rdcu_pkg::REG_INV_EPS:   prdata = {9'd0, r_inv_eps};
            rdcu_pkg::REG_STIMULUS:  prdata = {8'd0, r_stimulus};
            default:                 prdata = '0;
        endcase
    end

    assign c_h    = $signed({9'd0, r_time_step});
    assign c_gx   = $signed({9'd0, r_gain_x});
    assign c_gy   = $signed({9'd0, r_gain_y});
    assign c_ia   = $signed({9'd0, r_inv_a});
    assign c_ie   = $signed({9'd0, r_inv_eps});
    assign c_b    = ACC'(r_b_offset);
    assign c_stim = ACC'(r_stimulus);

    // Pipeline control: a stage loads when it is empty or its successor loads.
    logic [NST-1:0]  r_vld;
    logic [NST-1:0]  w_en;
    rdcu_pkg::t_cell r_st [NST];
    rdcu_pkg::t_cell n_st [NST];

    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (w_en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    logic signed [WORD_BITS-1:0] w_in [6];
    logic signed [ACC-1:0]       w_alt;
    logic                        w_mid;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_in[k] = $signed(s_axis_tdata[k*WORD_BITS +: WORD_BITS]);
        end
        for (int k = 1; k < NST; k++) begin
            n_st[k] = r_st[k-1];
        end

        // Stage 0: operand sums and the branch tests of the recovery term.
        n_st[0]      = '0;
        n_st[0].u    = ACC'(w_in[0]);
        n_st[0].v    = ACC'(w_in[1]);
        n_st[0].stim = s_axis_tuser[0];
        n_st[0].xs   = sat32(EXT'(ACC'(w_in[2])) + EXT'(ACC'(w_in[3])));
        n_st[0].ys   = sat32(EXT'(ACC'(w_in[4])) + EXT'(ACC'(w_in[5])));
        n_st[0].tu   = sat32(EXT'(ACC'(w_in[1])) + EXT'(c_b));
        n_st[0].mu   = sat32(EXT'(ACC'(w_in[0])) - EXT'(ONE));
        n_st[0].sv   = n_st[0].mu;
        n_st[0].lo   = (EXT'(ACC'(w_in[0])) * 66'sd3) < EXT'(ONE);
        n_st[0].hi   = ACC'(w_in[0]) > ONE;
        n_st[0].cu   = ovf32(EXT'(ACC'(w_in[2])) + EXT'(ACC'(w_in[3])))
                    || ovf32(EXT'(ACC'(w_in[4])) + EXT'(ACC'(w_in[5])))
                    || ovf32(EXT'(ACC'(w_in[1])) + EXT'(c_b))
                    || ovf32(EXT'(ACC'(w_in[0])) - EXT'(ONE));

        // Stage 1: Laplacian differences; first products of both cubics.
        n_st[1].xs = sat32(EXT'(r_st[0].xs) - EXT'(r_st[0].u) - EXT'(r_st[0].u));
        n_st[1].ys = sat32(EXT'(r_st[0].ys) - EXT'(r_st[0].u) - EXT'(r_st[0].u));
        n_st[1].cu = r_st[0].cu
                  || ovf32(EXT'(r_st[0].xs) - EXT'(r_st[0].u) - EXT'(r_st[0].u))
                  || ovf32(EXT'(r_st[0].ys) - EXT'(r_st[0].u) - EXT'(r_st[0].u));
        n_st[1].pu = mul(r_st[0].tu, c_ia);
        n_st[1].pm = mul(r_st[0].u, r_st[0].mu);
        n_st[1].pv = mul(r_st[0].sv, r_st[0].sv);

        // Stage 2.
        n_st[2].px = mul(c_gx, r_st[1].xs);
        n_st[2].py = mul(c_gy, r_st[1].ys);
        n_st[2].tu = sat32(rnd(r_st[1].pu));
        n_st[2].mu = sat32(rnd(r_st[1].pm));
        n_st[2].sv = sat32(rnd(r_st[1].pv));
        n_st[2].cu = r_st[1].cu || ovf32(rnd(r_st[1].pu)) || ovf32(rnd(r_st[1].pm));
        n_st[2].cm = r_st[1].cm || ovf32(rnd(r_st[1].pv));

        // Stage 3.
        n_st[3].xs = sat32(rnd(r_st[2].px));
        n_st[3].ys = sat32(rnd(r_st[2].py));
        n_st[3].tu = sat32(EXT'(r_st[2].u) - EXT'(r_st[2].tu));
        n_st[3].pv = mul(r_st[2].u, r_st[2].sv);
        n_st[3].cu = r_st[2].cu || ovf32(rnd(r_st[2].px)) || ovf32(rnd(r_st[2].py))
                  || ovf32(EXT'(r_st[2].u) - EXT'(r_st[2].tu));

        // Stage 4.
        n_st[4].pm = mul(r_st[3].mu, r_st[3].tu);
        n_st[4].sv = sat32(rnd(r_st[3].pv));
        n_st[4].cm = r_st[3].cm || ovf32(rnd(r_st[3].pv));

        // Stage 5.
        n_st[5].mu = sat32(rnd(r_st[4].pm));
        n_st[5].cu = r_st[4].cu || ovf32(rnd(r_st[4].pm));
        n_st[5].pv = mul(r_st[4].sv, K675);

        // Stage 6.
        n_st[6].pm = mul(r_st[5].mu, c_ie);
        n_st[6].sv = sat32(rnd(r_st[5].pv));
        n_st[6].cm = r_st[5].cm || ovf32(rnd(r_st[5].pv));

        // Stage 7.
        n_st[7].mu = sat32(rnd(r_st[6].pm));
        n_st[7].cu = r_st[6].cu || ovf32(rnd(r_st[6].pm));
        n_st[7].sv = sat32(EXT'(ONE) - EXT'(r_st[6].sv));
        n_st[7].cm = r_st[6].cm || ovf32(EXT'(ONE) - EXT'(r_st[6].sv));

        // Stage 8: reaction term changes sign; middle recovery segment ends.
        n_st[8].mu = sat32(-EXT'(r_st[7].mu));
        n_st[8].cu = r_st[7].cu || ovf32(-EXT'(r_st[7].mu));
        n_st[8].sv = sat32(EXT'(r_st[7].sv) - EXT'(r_st[7].v));
        n_st[8].cm = r_st[7].cm || ovf32(EXT'(r_st[7].sv) - EXT'(r_st[7].v));

        // Stage 9: pick the recovery segment. Clips of the middle segment
        // count only when that segment is the one taken.
        w_mid = !r_st[8].lo && !r_st[8].hi;
        if (r_st[8].lo) begin
            w_alt = sat32(-EXT'(r_st[8].v));
        end else begin
            w_alt = sat32(EXT'(ONE) - EXT'(r_st[8].v));
        end
        n_st[9].dv = w_mid ? r_st[8].sv : w_alt;
        n_st[9].du = sat32(EXT'(r_st[8].mu) + EXT'(r_st[8].xs));
        n_st[9].cu = r_st[8].cu || ovf32(EXT'(r_st[8].mu) + EXT'(r_st[8].xs))
                  || (w_mid ? r_st[8].cm
                            : (r_st[8].lo ? ovf32(-EXT'(r_st[8].v))
                                          : ovf32(EXT'(ONE) - EXT'(r_st[8].v))));

        // Stage 10.
        n_st[10].du = sat32(EXT'(r_st[9].du) + EXT'(r_st[9].ys));
        n_st[10].cu = r_st[9].cu || ovf32(EXT'(r_st[9].du) + EXT'(r_st[9].ys));

        // Stage 11: stimulus, and the time step applied to dv.
        if (r_st[10].stim) begin
            n_st[11].du = sat32(EXT'(r_st[10].du) + EXT'(c_stim));
            n_st[11].cu = r_st[10].cu || ovf32(EXT'(r_st[10].du) + EXT'(c_stim));
        end
        n_st[11].pv = mul(c_h, r_st[10].dv);

        // Stage 12.
        n_st[12].pm = mul(c_h, r_st[11].du);
        n_st[12].dv = sat32(rnd(r_st[11].pv));
        n_st[12].cu = r_st[11].cu || ovf32(rnd(r_st[11].pv));

        // Stage 13.
        n_st[13].du = sat32(rnd(r_st[12].pm));
        n_st[13].dv = sat32(EXT'(r_st[12].v) + EXT'(r_st[12].dv));
        n_st[13].cu = r_st[12].cu || ovf32(rnd(r_st[12].pm))
                   || ovf32(EXT'(r_st[12].v) + EXT'(r_st[12].dv));

        // Stage 14.
        n_st[14].du = sat32(EXT'(r_st[13].u) + EXT'(r_st[13].du));
        n_st[14].dv = satw(r_st[13].dv);
        n_st[14].cu = r_st[13].cu || ovf32(EXT'(r_st[13].u) + EXT'(r_st[13].du))
                   || ovfw(r_st[13].dv);

        // Stage 15: output register.
        n_st[15].du = satw(r_st[14].du);
        n_st[15].cu = r_st[14].cu || ovfw(r_st[14].du);
    end

    assign m_axis_tvalid = r_vld[NST-1];
    assign m_axis_tdata  = OUT_BITS'({r_st[NST-1].dv[WORD_BITS-1:0],
                                      r_st[NST-1].du[WORD_BITS-1:0]});
    assign m_axis_tuser  = r_st[NST-1].cu;

`ifndef SYNTHESIS
    // Bubbles always fill, so input back-pressure means a full, stalled pipe.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld) && !m_axis_tready)
        else $error("input stalled while the pipeline has room");

    // Cells in flight change only by accepted requests and delivered results.
    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> $countones(r_vld) == $past($countones(r_vld))
            + $past(int'(s_axis_tvalid && s_axis_tready))
            - $past(int'(m_axis_tvalid && m_axis_tready)))
        else $error("cell lost or duplicated in the pipeline");

    // The low and high recovery branches exclude each other.
    a_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> !(r_st[0].lo && r_st[0].hi))
        else $error("both recovery branches selected");
`endif

endmodule
